// ----- rtl/shcl_pkg.sv -----
// Package for the shell command lexer: result and queue entry types,
// character codes and output field codes. No dependencies.
package shcl_pkg;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_PIPE   = 8'h7C;

  localparam logic [1:0] KIND_BYTE     = 2'd0;
  localparam logic [1:0] KIND_TOK_END  = 2'd1;
  localparam logic [1:0] KIND_LINE_END = 2'd2;

  localparam logic [1:0] CLASS_WORD   = 2'd0;
  localparam logic [1:0] CLASS_QUOTED = 2'd1;
  localparam logic [1:0] CLASS_OPER   = 2'd2;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_TOO_MANY  = 2'd1;
  localparam logic [1:0] STATUS_TRUNCATED = 2'd2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] byte_out;
    logic [1:0] token_class;
    logic [1:0] line_status;
    logic       last;
  } shcl_res_t;

  typedef struct packed {
    logic      two;
    shcl_res_t r0;
    shcl_res_t r1;
  } shcl_entry_t;

endpackage

// ----- rtl/shcl_front.sv -----
// Front end of the shell command lexer: accepts characters, keeps the lexer
// state and writes the results of each character, if any, to the queue.
// Depends on shcl_pkg.
module shcl_front import shcl_pkg::*; #(
  parameter int MAX_TOKENS      = 128,
  parameter int MAX_TOKEN_BYTES = 255
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  char_in,
  input  logic        q_full,
  output logic        q_wr,
  output shcl_entry_t q_data
);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_WORD,
    MODE_QUOTE,
    MODE_OPER
  } mode_t;

  localparam logic [7:0] MaxTok   = 8'(MAX_TOKENS);
  localparam logic [7:0] MaxBytes = 8'(MAX_TOKEN_BYTES);

  mode_t      mode_r, mode_nxt;
  logic       qd_r, qd_nxt;
  logic [7:0] op_r, op_nxt;
  logic [7:0] ts_r, ts_nxt;
  logic [7:0] tl_r, tl_nxt;
  logic [1:0] ef_r, ef_nxt;

  shcl_res_t  res [2];
  logic [1:0] cnt;
  logic       accept;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    logic       p1_push;
    logic       p1_end;
    logic [1:0] cls;
    logic       le;
    logic       go_idle;
    logic       is_op;
    logic [7:0] qch;
    logic [1:0] st;

    mode_nxt = mode_r;
    qd_nxt   = qd_r;
    op_nxt   = op_r;
    ts_nxt   = ts_r;
    tl_nxt   = tl_r;
    ef_nxt   = ef_r;
    cnt      = 2'd0;
    res[0]   = '0;
    res[1]   = '0;
    p1_push  = 1'b0;
    p1_end   = 1'b0;
    cls      = CLASS_WORD;
    le       = 1'b0;
    go_idle  = 1'b0;
    st       = STATUS_OK;
    is_op    = char_in inside {CH_GT, CH_LT, CH_PIPE, CH_SEMI, CH_AMP};
    qch      = qd_r ? CH_DQUOTE : CH_SQUOTE;

    case (mode_r)
      MODE_WORD: begin
        cls = CLASS_WORD;
        if (char_in == CH_NUL) begin
          p1_end = 1'b1;
          le     = 1'b1;
        end else if (char_in == CH_SPACE) begin
          p1_end = 1'b1;
        end else if (is_op) begin
          p1_end  = 1'b1;
          go_idle = 1'b1;
        end else begin
          p1_push = 1'b1;
        end
      end
      MODE_QUOTE: begin
        cls = CLASS_QUOTED;
        if (char_in == qch) begin
          p1_end = 1'b1;
        end else if (char_in == CH_NUL) begin
          p1_end = 1'b1;
          le     = 1'b1;
        end else begin
          p1_push = 1'b1;
        end
      end
      MODE_OPER: begin
        cls    = CLASS_OPER;
        p1_end = 1'b1;
        if (char_in == op_r && (char_in inside {CH_PIPE, CH_AMP, CH_GT})) begin
          p1_push = 1'b1;
        end else begin
          go_idle = 1'b1;
        end
      end
      default: begin
        go_idle = 1'b1;
      end
    endcase

    if (p1_push && !ef_nxt[0]) begin
      if (tl_nxt >= MaxBytes) begin
        ef_nxt[1] = 1'b1;
      end else begin
        tl_nxt = tl_nxt + 8'd1;
        res[cnt[0]] = '{kind: KIND_BYTE, byte_out: char_in, token_class: CLASS_WORD,
                        line_status: STATUS_OK, last: 1'b0};
        cnt = cnt + 2'd1;
      end
    end

    if (p1_end) begin
      mode_nxt = MODE_IDLE;
      if (!ef_nxt[0]) begin
        res[cnt[0]] = '{kind: KIND_TOK_END, byte_out: 8'd0, token_class: cls,
                        line_status: STATUS_OK, last: 1'b0};
        cnt = cnt + 2'd1;
      end
    end

    if (go_idle) begin
      if (char_in == CH_NUL) begin
        le = 1'b1;
      end else if (char_in != CH_SPACE) begin
        tl_nxt = 8'd0;
        if (!ef_nxt[0]) begin
          if (ts_nxt >= MaxTok) begin
            ef_nxt[0] = 1'b1;
          end else begin
            ts_nxt = ts_nxt + 8'd1;
          end
        end
        if (char_in == CH_DQUOTE || char_in == CH_SQUOTE) begin
          mode_nxt = MODE_QUOTE;
          qd_nxt   = (char_in == CH_DQUOTE);
        end else begin
          if (is_op) begin
            mode_nxt = MODE_OPER;
            op_nxt   = char_in;
          end else begin
            mode_nxt = MODE_WORD;
          end
          if (!ef_nxt[0]) begin
            if (tl_nxt >= MaxBytes) begin
              ef_nxt[1] = 1'b1;
            end else begin
              tl_nxt = tl_nxt + 8'd1;
              res[cnt[0]] = '{kind: KIND_BYTE, byte_out: char_in,
                              token_class: CLASS_WORD, line_status: STATUS_OK,
                              last: 1'b0};
              cnt = cnt + 2'd1;
            end
          end
        end
      end
    end

    if (le) begin
      if (ef_nxt[0]) begin
        st = STATUS_TOO_MANY;
      end else if (ef_nxt[1]) begin
        st = STATUS_TRUNCATED;
      end else begin
        st = STATUS_OK;
      end
      res[cnt[0]] = '{kind: KIND_LINE_END, byte_out: 8'd0, token_class: CLASS_WORD,
                      line_status: st, last: 1'b0};
      cnt      = cnt + 2'd1;
      mode_nxt = MODE_IDLE;
      qd_nxt   = 1'b0;
      op_nxt   = 8'd0;
      ts_nxt   = 8'd0;
      tl_nxt   = 8'd0;
      ef_nxt   = 2'd0;
    end

    if (cnt != 2'd0) begin
      res[1'(cnt - 2'd1)].last = 1'b1;
    end
  end

  assign q_wr        = accept && (cnt != 2'd0);
  assign q_data.two  = (cnt == 2'd2);
  assign q_data.r0   = res[0];
  assign q_data.r1   = res[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      qd_r   <= 1'b0;
      op_r   <= 8'd0;
      ts_r   <= 8'd0;
      tl_r   <= 8'd0;
      ef_r   <= 2'd0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      qd_r   <= qd_nxt;
      op_r   <= op_nxt;
      ts_r   <= ts_nxt;
      tl_r   <= tl_nxt;
      ef_r   <= ef_nxt;
    end
  end

endmodule

// ----- rtl/shcl_queue.sv -----
// Short queue between the lexer front end and the output back end.
// Each entry holds the one or two results of one character. Depends on shcl_pkg.
module shcl_queue import shcl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr,
  input  shcl_entry_t wr_data,
  output logic        full,
  input  logic        rd,
  output logic        empty,
  output shcl_entry_t rd_data
);

  shcl_entry_t               mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]       wr_ptr_r;
  logic [QUEUE_AW-1:0]       rd_ptr_r;
  logic [QUEUE_AW:0]         count_r;

  assign full    = (count_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (rd) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (wr && !rd) begin
        count_r <= count_r + 1'b1;
      end else if (rd && !wr) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/shcl_back.sv -----
// Back end of the shell command lexer: takes queue entries and sends their
// results one at a time through the output register. Depends on shcl_pkg.
module shcl_back import shcl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  shcl_entry_t q_data,
  output logic        q_rd,
  output logic        out_tvalid,
  input  logic        out_tready,
  output shcl_res_t   out_res
);

  logic      valid_r;
  logic      second_r;
  shcl_res_t res_r;
  logic      load;

  assign load       = (!valid_r || out_tready) && !q_empty;
  assign q_rd       = load && (second_r || !q_data.two);
  assign out_tvalid = valid_r;
  assign out_res    = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      second_r <= 1'b0;
    end else begin
      if (load) begin
        valid_r  <= 1'b1;
        second_r <= q_data.two && !second_r;
      end else if (out_tready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= second_r ? q_data.r1 : q_data.r0;
    end
  end

endmodule

// ----- rtl/shell_command_lexer_core.sv -----
// Shell command line lexer. One character enters per cycle on the input stream
// while the queue has room; a zero byte ends the line. Each character yields
// zero, one or two results (token bytes, token ends with a class, a line end
// with a status), which pass through the queue and the output register. The
// output register sends one result per cycle while out_tready is high, so a
// character with two results is sent as two transfers; a four-entry queue
// ahead of the output absorbs these, and the input stalls only when it is full.
// Depends on shcl_pkg, shcl_front, shcl_queue and shcl_back.
module shell_command_lexer_core import shcl_pkg::*; #(
  parameter int MAX_TOKENS      = 128,
  parameter int MAX_TOKEN_BYTES = 255
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] byte_out, [9:8] token_class,
                                  // [11:10] line_status, [15:12] zero
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast
);

  logic        q_wr;
  logic        q_rd;
  logic        q_full;
  logic        q_empty;
  shcl_entry_t q_wr_data;
  shcl_entry_t q_rd_data;
  shcl_res_t   res;

  shcl_front #(
    .MAX_TOKENS      (MAX_TOKENS),
    .MAX_TOKEN_BYTES (MAX_TOKEN_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .char_in   (in_tdata),
    .q_full    (q_full),
    .q_wr      (q_wr),
    .q_data    (q_wr_data)
  );

  shcl_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (q_wr),
    .wr_data (q_wr_data),
    .full    (q_full),
    .rd      (q_rd),
    .empty   (q_empty),
    .rd_data (q_rd_data)
  );

  shcl_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_data     (q_rd_data),
    .q_rd       (q_rd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (res)
  );

  assign out_tdata = {4'd0, res.line_status, res.token_class, res.byte_out};
  assign out_tuser = res.kind;
  assign out_tlast = res.last;

endmodule
